FILE: src/mkc_pkg.sv
// Shared types and constants of the masked 3x3 RGB convolution block.
package mkc_pkg;

  localparam int COEF_BITS = 8;
  localparam int CHAN_BITS = 8;
  localparam int PIX_BITS  = 3 * CHAN_BITS;
  localparam int ROW_BITS  = 3 * COEF_BITS;
  localparam int TAPS      = 9;
  localparam int SUM_BITS  = 20;
  localparam int MAG_BITS  = 19;
  localparam int DIV_BITS  = 12;
  localparam int LW_BITS   = 11;
  localparam int IDX_BITS  = 3;
  localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_KERNEL_TOP    = 3'd0,
    CFG_KERNEL_MIDDLE = 3'd1,
    CFG_KERNEL_BOTTOM = 3'd2,
    CFG_NORM_DIVISOR  = 3'd3,
    CFG_LINE_WIDTH    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_BITS-1:0] pix_red;
    logic [CHAN_BITS-1:0] pix_green;
    logic [CHAN_BITS-1:0] pix_blue;
    logic                 pix_selected;
    logic                 frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] out_red;
    logic [CHAN_BITS-1:0] out_green;
    logic [CHAN_BITS-1:0] out_blue;
    logic                 out_row_end;
  } pix_out_t;

  // pix[0] is the top-left tap, pix[8] the bottom-right one
  typedef struct packed {
    logic [TAPS-1:0][PIX_BITS-1:0] pix;
    logic                          centre_sel;
    logic                          row_end;
  } win_t;

  typedef struct packed {
    logic [2:0][ROW_BITS-1:0] kernel;
    logic [DIV_BITS-1:0]      norm_divisor;
  } coef_cfg_t;

endpackage

FILE: src/masked_kernel_convolution_rgb_unit.sv
// Top level of the masked 3x3 RGB convolution block.
//
// Pixels enter in raster order on the input channel (in_valid_i / in_stall_o,
// payload in_data_i); frame_start clears the column and row position.
// A word is taken when valid is high and stall is low. Windowed results
// leave on out_valid_o / out_stall_i / out_data_o, one word per pixel whose
// 3x3 window is complete (third row on, third column on).
// The line stores are read into registers and written back afterwards, so
// the front end stalls its input until the write-back of each pixel is done
// and, for a complete window, until the queue takes that window. The back
// end walks the nine taps serially and, with a nonzero divisor, runs a
// bit-serial divider; an unselected centre pixel skips both and passes
// straight to the output register. A two-word queue sits between front and
// back, so pixels are still taken while a result waits at the output.
// While out_stall_i is high the result holds; once the queue fills the
// input stalls. Reset empties the queue and clears positions; the line
// stores are not cleared. Configuration writes are always ready.
module masked_kernel_convolution_rgb_unit import mkc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pix_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IDX_BITS-1:0] cfg_index_i,
  input  logic [ROW_BITS-1:0] cfg_data_i
);

  coef_cfg_t          cfg_q;
  logic [LW_BITS-1:0] line_width_q;
  logic               push, full, pop, empty;
  win_t               push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel[0]    <= ROW_BITS'(0);
      cfg_q.kernel[1]    <= ROW_BITS'(256);
      cfg_q.kernel[2]    <= ROW_BITS'(0);
      cfg_q.norm_divisor <= '0;
      line_width_q       <= LW_BITS'(640);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KERNEL_TOP:    cfg_q.kernel[0]    <= cfg_data_i;
        CFG_KERNEL_MIDDLE: cfg_q.kernel[1]    <= cfg_data_i;
        CFG_KERNEL_BOTTOM: cfg_q.kernel[2]    <= cfg_data_i;
        CFG_NORM_DIVISOR:  cfg_q.norm_divisor <= cfg_data_i[DIV_BITS-1:0];
        CFG_LINE_WIDTH:    line_width_q       <= cfg_data_i[LW_BITS-1:0];
        default: ;
      endcase
    end
  end

  mkc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .line_width_i (line_width_q),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  mkc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .pop_data_o   (pop_data)
  );

  mkc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .win_i        (pop_data),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: src/mkc_front.sv
// Front end: accepts pixels, keeps the line stores and the 3x3 window, queues full windows.
module mkc_front import mkc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pix_in_t            in_data_i,
  input  logic [LW_BITS-1:0] line_width_i,
  output logic               push_o,
  output win_t               push_data_o,
  input  logic               full_i
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CMP_W = ((AW > LW_BITS) ? AW : LW_BITS) + 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic [AW-1:0]         col_q, colc_q, col_eff;
  logic [1:0]            row_q, rowc_q, row_eff;
  logic [PIX_BITS:0]     cur_q, up1_q, up2_q;
  logic [PIX_BITS:0]     win_q [TAPS];
  logic                  row_end_q;
  logic [PIX_BITS:0]     line1 [MAX_WIDTH];
  logic [PIX_BITS:0]     line2 [MAX_WIDTH];
  logic                  accept;
  logic [CMP_W-1:0]      w_eff, lw_ext;
  logic                  row_end, produce;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != F_IDLE);
  assign col_eff    = in_data_i.frame_start ? '0 : col_q;
  assign row_eff    = in_data_i.frame_start ? '0 : row_q;

  always_comb begin
    lw_ext = CMP_W'(line_width_i);
    if (lw_ext < CMP_W'(3)) begin
      w_eff = CMP_W'(3);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
  end

  assign row_end = CMP_W'(colc_q) >= (w_eff - CMP_W'(1));
  assign produce = (rowc_q == 2'd2) && (colc_q >= AW'(2));

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_READ;
      F_READ: state_d = produce ? F_PUSH : F_IDLE;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  assign push_o = (state_q == F_PUSH) && !full_i;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      push_data_o.pix[k] = win_q[k][PIX_BITS-1:0];
    end
    push_data_o.centre_sel = win_q[4][PIX_BITS];
    push_data_o.row_end    = row_end_q;
  end

  // Line stores: registered read at accept, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up1_q <= line1[col_eff];
      up2_q <= line2[col_eff];
    end
    if (state_q == F_READ) begin
      line2[colc_q] <= up1_q;
      line1[colc_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q  <= {in_data_i.pix_selected, in_data_i.pix_red,
                 in_data_i.pix_green, in_data_i.pix_blue};
    end
    if (state_q == F_READ) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2]  <= up2_q;
      win_q[5]  <= up1_q;
      win_q[8]  <= cur_q;
      row_end_q <= row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      colc_q  <= '0;
      rowc_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        colc_q <= col_eff;
        rowc_q <= row_eff;
      end
      if (state_q == F_READ) begin
        if (row_end) begin
          col_q <= '0;
          row_q <= (rowc_q == 2'd2) ? rowc_q : rowc_q + 2'd1;
        end else begin
          col_q <= colc_q + AW'(1);
          row_q <= rowc_q;
        end
      end
    end
  end

endmodule

FILE: src/mkc_queue.sv
// Two-entry window queue between front and back end.
module mkc_queue import mkc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  win_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output win_t pop_data_o
);

  win_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: src/mkc_back.sv
// Back end: tap-serial multiply-accumulate, bit-serial divide, clamp and output register.
module mkc_back import mkc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  win_t      win_i,
  output logic      pop_o,
  input  coef_cfg_t cfg_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pix_out_t  out_data_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MAC  = 4'b0010,
    B_DIV  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_e;

  back_state_e state_q;

  logic [TAPS-1:0][PIX_BITS-1:0] pix_q;
  logic [TAPS*COEF_BITS-1:0]     coef_q;
  logic [3:0]                    tap_q;
  logic [4:0]                    step_q;
  logic                          row_end_q;
  logic signed [SUM_BITS-1:0]    acc_q [3];
  logic [MAG_BITS-1:0]           dvd_q [3];
  logic [DIV_BITS-1:0]           rem_q [3];
  logic                          neg_q [3];
  logic [DIV_BITS-1:0]           dmag_q;
  logic [CHAN_BITS-1:0]          res_q [3];
  logic                          div_zero, div_neg;

  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign out_valid_o = (state_q == B_OUT);
  assign div_zero    = (cfg_i.norm_divisor == '0);
  assign div_neg     = cfg_i.norm_divisor[DIV_BITS-1];

  always_comb begin
    out_data_o.out_red     = res_q[0];
    out_data_o.out_green   = res_q[1];
    out_data_o.out_blue    = res_q[2];
    out_data_o.out_row_end = row_end_q;
  end

  always_ff @(posedge clk_i) begin
    logic signed [COEF_BITS-1:0]     cf;
    logic signed [CHAN_BITS:0]       px;
    logic signed [COEF_BITS+CHAN_BITS:0] prod;
    logic [SUM_BITS-1:0]             mag;
    logic [DIV_BITS:0]               trial;
    case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          pix_q     <= win_i.pix;
          coef_q    <= {cfg_i.kernel[2], cfg_i.kernel[1], cfg_i.kernel[0]};
          row_end_q <= win_i.row_end;
          tap_q     <= '0;
          for (int ch = 0; ch < 3; ch++) begin
            acc_q[ch] <= '0;
            res_q[ch] <= win_i.pix[4][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS];
          end
        end
      end
      B_MAC: begin
        if (tap_q != 4'(TAPS)) begin
          // one tap per cycle for all three channels, then advance
          cf = coef_q[COEF_BITS-1:0];
          for (int ch = 0; ch < 3; ch++) begin
            px   = $signed({1'b0, pix_q[0][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS]});
            prod = cf * px;
            acc_q[ch] <= acc_q[ch] + SUM_BITS'(prod);
          end
          pix_q  <= pix_q >> PIX_BITS;
          coef_q <= coef_q >> COEF_BITS;
          tap_q  <= tap_q + 4'd1;
        end else begin
          dmag_q <= div_neg ? DIV_BITS'(-cfg_i.norm_divisor) : cfg_i.norm_divisor;
          step_q <= '0;
          for (int ch = 0; ch < 3; ch++) begin
            mag = acc_q[ch][SUM_BITS-1] ? -acc_q[ch] : acc_q[ch];
            dvd_q[ch] <= mag[MAG_BITS-1:0];
            rem_q[ch] <= '0;
            neg_q[ch] <= acc_q[ch][SUM_BITS-1] ^ div_neg;
            if (acc_q[ch] < 0) begin
              res_q[ch] <= '0;
            end else if (acc_q[ch] > SUM_BITS'(CHAN_MAX)) begin
              res_q[ch] <= CHAN_MAX;
            end else begin
              res_q[ch] <= acc_q[ch][CHAN_BITS-1:0];
            end
          end
        end
      end
      B_DIV: begin
        if (step_q != 5'(MAG_BITS)) begin
          for (int ch = 0; ch < 3; ch++) begin
            trial = {rem_q[ch], dvd_q[ch][MAG_BITS-1]};
            if (trial >= {1'b0, dmag_q}) begin
              rem_q[ch] <= DIV_BITS'(trial - {1'b0, dmag_q});
              dvd_q[ch] <= {dvd_q[ch][MAG_BITS-2:0], 1'b1};
            end else begin
              rem_q[ch] <= trial[DIV_BITS-1:0];
              dvd_q[ch] <= {dvd_q[ch][MAG_BITS-2:0], 1'b0};
            end
          end
          step_q <= step_q + 5'd1;
        end else begin
          for (int ch = 0; ch < 3; ch++) begin
            if (neg_q[ch]) begin
              res_q[ch] <= '0;
            end else if (dvd_q[ch] > MAG_BITS'(CHAN_MAX)) begin
              res_q[ch] <= CHAN_MAX;
            end else begin
              res_q[ch] <= dvd_q[ch][CHAN_BITS-1:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      case (state_q)
        B_IDLE: if (pop_o) state_q <= win_i.centre_sel ? B_MAC : B_OUT;
        B_MAC: begin
          if (tap_q == 4'(TAPS)) state_q <= div_zero ? B_OUT : B_DIV;
        end
        B_DIV: if (step_q == 5'(MAG_BITS)) state_q <= B_OUT;
        B_OUT: if (!out_stall_i) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: src/mkc_checker.sv
// Port-level checker of the convolution block and its bind to the top level.
module mkc_checker import mkc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pix_out_t out_data_o,
  input logic     cfg_ready_o
);

  // the front end needs the cycle after an accept for the line store write-back
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken in two consecutive cycles");

  // the back end drops to idle after each delivered word
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result shown again right after delivery");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result dropped or changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind masked_kernel_convolution_rgb_unit mkc_checker u_mkc_checker (.*);

FILE: tb/masked_kernel_convolution_rgb_unit_tb.sv
// Self-checking testbench of the masked 3x3 RGB convolution unit.
`timescale 1ns / 100ps

module masked_kernel_convolution_rgb_unit_tb;
  import mkc_pkg::*;

  localparam int MAXW = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  pix_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  pix_out_t            out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index;
  logic [ROW_BITS-1:0] cfg_data;

  masked_kernel_convolution_rgb_unit #(.MAX_WIDTH(MAXW)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor copy of configuration and state
  logic [ROW_BITS-1:0] krow [3];
  logic [DIV_BITS-1:0] divisor;
  logic [LW_BITS-1:0]  width_reg;
  logic [24:0]         lines [2*MAXW];
  logic [24:0]         win [9];
  int unsigned         col_pos, row_pos;

  pix_in_t  pixel_q [$];
  pix_out_t filtered_q [$];

  int  errors = 0;
  int  pixels_sent = 0;
  int  words_seen = 0;
  longint cycles = 0;
  bit  hold_off = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[masked_kernel_convolution_rgb_unit] ERROR");
      $finish;
    end
  end

  function automatic int kcoef(logic [ROW_BITS-1:0] r, int j);
    logic signed [COEF_BITS-1:0] v;
    v = r[j*COEF_BITS +: COEF_BITS];
    return int'(v);
  endfunction

  function automatic logic [7:0] scale_clamp(int sum);
    int d;
    int s;
    d = int'($signed(divisor));
    s = sum;
    if (d != 0) s = s / d;
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return s[7:0];
  endfunction

  function automatic void reset_model();
    krow[0] = '0; krow[1] = 24'd256; krow[2] = '0;
    divisor = '0; width_reg = 11'd640;
    foreach (lines[i]) lines[i] = '0;
    foreach (win[i]) win[i] = '0;
    col_pos = 0; row_pos = 0;
  endfunction

  function automatic void convolve_pixel(pix_in_t p);
    int unsigned w, c;
    logic [24:0] cur, up1, up2, ctr;
    bit rend;
    pix_out_t r;
    int sum;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAXW) w = MAXW;
    if (p.frame_start) begin
      col_pos = 0; row_pos = 0;
    end
    cur = {p.pix_selected, p.pix_red, p.pix_green, p.pix_blue};
    c = (col_pos >= MAXW) ? MAXW - 1 : col_pos;
    up1 = lines[c];
    up2 = lines[MAXW + c];
    lines[MAXW + c] = up1;
    lines[c] = cur;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = up2; win[5] = up1; win[8] = cur;
    rend = col_pos >= w - 1;
    if (row_pos >= 2 && col_pos >= 2) begin
      ctr = win[4];
      if (ctr[24]) begin
        for (int ch = 0; ch < 3; ch++) begin
          sum = 0;
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              sum += kcoef(krow[i], j) * int'(win[i*3+j][16-8*ch +: 8]);
          if (ch == 0) r.out_red = scale_clamp(sum);
          else if (ch == 1) r.out_green = scale_clamp(sum);
          else r.out_blue = scale_clamp(sum);
        end
      end else begin
        r.out_red = ctr[23:16]; r.out_green = ctr[15:8]; r.out_blue = ctr[7:0];
      end
      r.out_row_end = rend;
      filtered_q.push_back(r);
    end
    if (rend) begin
      col_pos = 0;
      if (row_pos < 65535) row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  // driver: random gaps, most short and a few long
  int gap = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap      <= 0;
    end else if (in_valid && !in_stall) begin
      convolve_pixel(in_data);
      pixels_sent <= pixels_sent + 1;
      if (gap == 0 && pixel_q.size() != 0 && $urandom_range(0, 3) != 0) begin
        in_data <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      end
    end else if (!in_valid) begin
      if (gap != 0) begin
        gap <= gap - 1;
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pixel_q.pop_front();
      end
    end
  end

  // monitor and receiver stall
  int stall_len = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_len <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen <= words_seen + 1;
        if (filtered_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected word %h", out_data);
        end else begin
          if (filtered_q[0] !== out_data) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: exp r%h g%h b%h e%b got r%h g%h b%h e%b",
                filtered_q[0].out_red, filtered_q[0].out_green,
                filtered_q[0].out_blue, filtered_q[0].out_row_end,
                out_data.out_red, out_data.out_green, out_data.out_blue,
                out_data.out_row_end);
          end
          void'(filtered_q.pop_front());
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_len != 0) begin
        stall_len <= stall_len - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_len <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [ROW_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_KERNEL_TOP:    krow[0] = val;
      CFG_KERNEL_MIDDLE: krow[1] = val;
      CFG_KERNEL_BOTTOM: krow[2] = val;
      CFG_NORM_DIVISOR:  divisor = val[DIV_BITS-1:0];
      CFG_LINE_WIDTH:    width_reg = val[LW_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || filtered_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic pix_in_t rand_pixel(bit fs, int mode);
    pix_in_t p;
    p.pix_red = 8'($urandom); p.pix_green = 8'($urandom); p.pix_blue = 8'($urandom);
    if (mode == 1) begin
      p.pix_red = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
      p.pix_green = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
      p.pix_blue = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
    end
    p.pix_selected = ($urandom_range(0, 4) != 0);
    p.frame_start = fs;
    return p;
  endfunction

  task automatic queue_frame(int w, int rows);
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < w; x++)
        pixel_q.push_back(rand_pixel(x == 0 && y == 0, int'($urandom_range(0, 2))));
  endtask

  function automatic logic [ROW_BITS-1:0] rand_row();
    return $urandom_range(0, 3) == 0 ? {3{8'h80}} : ROW_BITS'($urandom);
  endfunction

  int lw;
  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // identity kernel at narrowest width, extremes of all channels
    write_reg(CFG_LINE_WIDTH, 24'd3);
    pixel_q.push_back('{8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1});
    pixel_q.push_back('{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0});
    pixel_q.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0});
    for (int i = 0; i < 12; i++) pixel_q.push_back(rand_pixel(0, 1));
    drain();
    // width below minimum acts as three; extreme kernel rows (-128, +127, -1), no division
    write_reg(CFG_LINE_WIDTH, 24'd0);
    write_reg(CFG_KERNEL_TOP, {3{8'h80}});
    write_reg(CFG_KERNEL_MIDDLE, {3{8'h7F}});
    write_reg(CFG_KERNEL_BOTTOM, {3{8'hFF}});
    queue_frame(3, 3);
    drain();
    // Laplace-like kernel, most negative divisor; width above maximum saturates,
    // so the first row ends at the last column, then narrow down and go on
    write_reg(CFG_KERNEL_TOP, 24'h00FF00);
    write_reg(CFG_KERNEL_MIDDLE, 24'hFF04FF);
    write_reg(CFG_KERNEL_BOTTOM, 24'h00FF00);
    write_reg(CFG_NORM_DIVISOR, 24'h800);
    write_reg(CFG_LINE_WIDTH, 24'h7FF);
    queue_frame(MAXW, 1);
    drain();
    write_reg(CFG_LINE_WIDTH, 24'd3);
    for (int i = 0; i < 12; i++) pixel_q.push_back(rand_pixel(0, 0));
    drain();

    // random phases: mostly small widths, random kernels and divisors
    for (int ph = 0; ph < 5; ph++) begin
      lw = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 8);
      write_reg(CFG_LINE_WIDTH, ROW_BITS'(lw));
      write_reg(CFG_KERNEL_TOP, rand_row());
      write_reg(CFG_KERNEL_MIDDLE, rand_row());
      write_reg(CFG_KERNEL_BOTTOM, rand_row());
      case ($urandom_range(0, 3))
        0: write_reg(CFG_NORM_DIVISOR, 24'd0);
        1: write_reg(CFG_NORM_DIVISOR, 24'h7FF);
        2: write_reg(CFG_NORM_DIVISOR, ROW_BITS'($urandom_range(1, 16)));
        default: write_reg(CFG_NORM_DIVISOR, 24'(12'(-$urandom_range(1, 20))));
      endcase
      queue_frame(lw, int'($urandom_range(3, 6)));
      // sometimes run on without a new frame, or drop in a stray restart
      if ($urandom_range(0, 1)) pixel_q.push_back(rand_pixel(1, 0));
      for (int k = 0; k < lw * 2; k++) pixel_q.push_back(rand_pixel(0, 0));
      if (ph == 2) begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    repeat (100) @(posedge clk);
    $display("sent %0d pixels, checked %0d output words over several kernels and widths",
             pixels_sent, words_seen);
    if (errors == 0 && filtered_q.size() == 0)
      $display("[masked_kernel_convolution_rgb_unit] OK");
    else
      $display("[masked_kernel_convolution_rgb_unit] ERROR");
    $finish;
  end

endmodule
